// ===== rtl/core/ivts_pkg.sv =====
`timescale 1ns / 1ps

package ivts_pkg;

  // Statistics sizing
  localparam int INTERVAL_BITS = 24;
  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 8;

  // Stream field widths
  localparam int MODE_W    = 2;
  localparam int TS_W      = 32;
  localparam int IVL_OUT_W = 24;
  localparam int CNT_OUT_W = 16;
  localparam int MEAN_W    = 32;
  localparam int VAR_W     = 48;
  localparam int SD_W      = 32;

  // Accumulator and work register widths
  localparam int SUM_W      = INTERVAL_BITS + COUNT_BITS;
  localparam int SQ_W       = 2 * INTERVAL_BITS + COUNT_BITS;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int MEAN_DVD_W = SUM_W + FRACTION_BITS;
  localparam int SQRT_IN_W  = VAR_W + 2 * FRACTION_BITS;
  localparam int WORK_W     = (PROD_W > SQRT_IN_W) ? PROD_W : SQRT_IN_W;
  localparam int ITER_W     = $clog2(WORK_W + 1);
  localparam int DIV_REM_W  = COUNT_BITS + 1;
  localparam int SQRT_REM_W = SD_W + 3;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAP   = 2'd2;

  // Result packing
  localparam int OUT_FIELDS_W = IVL_OUT_W + 1 + CNT_OUT_W + MEAN_W + VAR_W + SD_W
                                + 2 * IVL_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W        = OUT_TDATA_W - OUT_FIELDS_W;

  typedef struct packed {
    logic [PAD_W-1:0]     pad;
    logic [IVL_OUT_W-1:0] shortest;
    logic [IVL_OUT_W-1:0] longest;
    logic [SD_W-1:0]      std_dev_q8;
    logic [VAR_W-1:0]     variance_int;
    logic [MEAN_W-1:0]    mean_q8;
    logic [CNT_OUT_W-1:0] sample_count;
    logic                 interval_valid;
    logic [IVL_OUT_W-1:0] interval;
  } result_t;

endpackage

// ===== rtl/core/interval_timing_statistics_core.sv =====
`timescale 1ns / 1ps
// Lap timer statistics over one input stream and one result stream.
// Input request: tuser carries the mode (clear and mark, mark only, measure lap),
// tdata the 32-bit millisecond timestamp. Every request yields one result with
// the last lap, count, mean (8 fraction bits), sample variance, standard
// deviation (8 fraction bits), longest and shortest lap.
// One request is worked on at a time; s_axis_tready_o is high only while idle.
// The divides, the square of the sum and the root run through a bit-serial
// restoring divider, a shift-add squarer and a two-bit-per-cycle square root
// under one sequencer: accept, lap update, accumulate, setup, mean divide,
// square of the sum, its divide by the count, variance divide, root, result.
// Below two samples it stops after the mean divide, with none after setup.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds in its last step if the receiver stalls.
// Reset clears the statistics, the start mark and the output valid.
module interval_timing_statistics_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ivts_pkg::TS_W-1:0]        s_axis_tdata_i,  // timestamp
  input  logic [ivts_pkg::MODE_W-1:0]      s_axis_tuser_i,  // mode
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // interval, interval_valid, sample_count, mean_q8, variance_int,
  // std_dev_q8, longest, shortest, zero pad
  output logic [ivts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);
  import ivts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAP,
    ST_ACCUM,
    ST_SETUP,
    ST_MEAN,
    ST_MUL,
    ST_SQDIV,
    ST_VARDIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  state_e                   state_q;
  logic [MODE_W-1:0]        mode_q;
  logic [TS_W-1:0]          ts_q;
  logic [TS_W-1:0]          mark_q;
  logic [COUNT_BITS-1:0]    count_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SQ_W-1:0]          sq_sum_q;
  logic [INTERVAL_BITS-1:0] max_q;
  logic [INTERVAL_BITS-1:0] min_q;
  logic [INTERVAL_BITS-1:0] last_q;
  logic                     seen_q;
  logic [INTERVAL_BITS-1:0] lap_q;
  logic [WORK_W-1:0]        work_q;
  logic [DIV_REM_W-1:0]     div_rem_q;
  logic [COUNT_BITS-1:0]    divisor_q;
  logic [SQRT_REM_W-1:0]    sqrt_rem_q;
  logic [SD_W-1:0]          root_q;
  logic [ITER_W-1:0]        iter_q;
  logic [MEAN_W-1:0]        mean_q;
  logic [VAR_W-1:0]         var_q;
  result_t                  out_q;
  logic                     out_valid_q;

  logic [TS_W-1:0]            lap_diff;
  logic [INTERVAL_BITS-1:0]   lap_sat;
  logic [2*INTERVAL_BITS-1:0] lap_sq;
  logic [DIV_REM_W-1:0]       div_shift;
  logic                       div_ge;
  logic [DIV_REM_W-1:0]       div_rem_nxt;
  logic [WORK_W-1:0]          div_work_nxt;
  logic [SUM_W:0]             mul_sum;
  logic [WORK_W-1:0]          mul_work_nxt;
  logic [WORK_W-1:0]          sq_ext;
  logic [SQ_W-1:0]            var_diff;
  logic [SQRT_REM_W-1:0]      sqrt_shift;
  logic [SQRT_REM_W-1:0]      sqrt_trial;
  logic                       sqrt_ge;
  logic [SQRT_REM_W-1:0]      sqrt_rem_nxt;
  logic                       iter_last;

  always_comb begin
    lap_diff = ts_q - mark_q;
    lap_sat  = (lap_diff[TS_W-1:INTERVAL_BITS] != '0) ? '1 : lap_diff[INTERVAL_BITS-1:0];
    lap_sq   = lap_q * lap_q;

    // Restoring divider: one quotient bit per cycle, quotient enters at the bottom
    div_shift    = {div_rem_q[DIV_REM_W-2:0], work_q[WORK_W-1]};
    div_ge       = (div_shift >= {1'b0, divisor_q});
    div_rem_nxt  = div_ge ? (div_shift - {1'b0, divisor_q}) : div_shift;
    div_work_nxt = {work_q[WORK_W-2:0], div_ge};

    // Shift-add squarer on the top PROD_W bits: multiplier in the low half
    mul_sum      = {1'b0, work_q[WORK_W-1 -: SUM_W]}
                   + (work_q[WORK_W-PROD_W] ? {1'b0, sum_q} : '0);
    mul_work_nxt = WORK_W'({mul_sum, work_q[WORK_W-SUM_W-1 -: SUM_W-1]})
                   << (WORK_W - PROD_W);

    // Sum of squares minus floor(sum^2 / n), clamped at zero
    sq_ext   = WORK_W'(sq_sum_q);
    var_diff = (sq_ext >= div_work_nxt) ? SQ_W'(sq_ext - div_work_nxt) : '0;

    // Digit-by-digit square root, two radicand bits per cycle
    sqrt_shift   = {sqrt_rem_q[SQRT_REM_W-3:0], work_q[WORK_W-1 -: 2]};
    sqrt_trial   = {1'b0, root_q, 2'b01};
    sqrt_ge      = (sqrt_shift >= sqrt_trial);
    sqrt_rem_nxt = sqrt_ge ? (sqrt_shift - sqrt_trial) : sqrt_shift;

    iter_last = (iter_q == ITER_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      ts_q        <= '0;
      mark_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      sq_sum_q    <= '0;
      max_q       <= '0;
      min_q       <= '1;
      last_q      <= '0;
      seen_q      <= 1'b0;
      lap_q       <= '0;
      work_q      <= '0;
      div_rem_q   <= '0;
      divisor_q   <= '0;
      sqrt_rem_q  <= '0;
      root_q      <= '0;
      iter_q      <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // ST_OUT reloads the register itself when it is taken on this edge
      if (out_valid_q && m_axis_tready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            mode_q  <= s_axis_tuser_i;
            ts_q    <= s_axis_tdata_i;
            state_q <= ST_LAP;
          end
        end

        ST_LAP: begin
          case (mode_q)
            MODE_CLEAR: begin
              count_q  <= '0;
              sum_q    <= '0;
              sq_sum_q <= '0;
              max_q    <= '0;
              min_q    <= '1;
              last_q   <= '0;
              seen_q   <= 1'b0;
              mark_q   <= ts_q;
            end
            MODE_MARK: begin
              mark_q <= ts_q;
            end
            MODE_LAP: begin
              last_q <= lap_sat;
              lap_q  <= lap_sat;
              seen_q <= 1'b1;
              mark_q <= ts_q;
            end
            default: begin
            end
          endcase
          state_q <= ST_ACCUM;
        end

        ST_ACCUM: begin
          // Freeze the statistics once the count is full
          if (mode_q == MODE_LAP && count_q != '1) begin
            count_q  <= count_q + COUNT_BITS'(1);
            sum_q    <= sum_q + SUM_W'(lap_q);
            sq_sum_q <= sq_sum_q + SQ_W'(lap_sq);
            if (lap_q > max_q) begin
              max_q <= lap_q;
            end
            if (lap_q < min_q) begin
              min_q <= lap_q;
            end
          end
          state_q <= ST_SETUP;
        end

        ST_SETUP: begin
          if (count_q == '0) begin
            mean_q  <= '0;
            var_q   <= '0;
            root_q  <= '0;
            state_q <= ST_OUT;
          end else begin
            work_q    <= WORK_W'(sum_q) << (WORK_W - SUM_W);
            div_rem_q <= '0;
            divisor_q <= count_q;
            iter_q    <= ITER_W'(MEAN_DVD_W);
            state_q   <= ST_MEAN;
          end
        end

        ST_MEAN: begin
          work_q    <= div_work_nxt;
          div_rem_q <= div_rem_nxt;
          iter_q    <= iter_q - ITER_W'(1);
          if (iter_last) begin
            mean_q <= div_work_nxt[MEAN_W-1:0];
            if (count_q < COUNT_BITS'(2)) begin
              var_q   <= '0;
              root_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              work_q  <= WORK_W'(sum_q) << (WORK_W - PROD_W);
              iter_q  <= ITER_W'(SUM_W);
              state_q <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          work_q <= mul_work_nxt;
          iter_q <= iter_q - ITER_W'(1);
          if (iter_last) begin
            // Product is already left-aligned as the next dividend
            div_rem_q <= '0;
            iter_q    <= ITER_W'(PROD_W);
            state_q   <= ST_SQDIV;
          end
        end

        ST_SQDIV: begin
          work_q    <= div_work_nxt;
          div_rem_q <= div_rem_nxt;
          iter_q    <= iter_q - ITER_W'(1);
          if (iter_last) begin
            work_q    <= WORK_W'(var_diff) << (WORK_W - SQ_W);
            div_rem_q <= '0;
            divisor_q <= count_q - COUNT_BITS'(1);
            iter_q    <= ITER_W'(SQ_W);
            state_q   <= ST_VARDIV;
          end
        end

        ST_VARDIV: begin
          work_q    <= div_work_nxt;
          div_rem_q <= div_rem_nxt;
          iter_q    <= iter_q - ITER_W'(1);
          if (iter_last) begin
            var_q      <= div_work_nxt[VAR_W-1:0];
            work_q     <= WORK_W'(div_work_nxt[VAR_W-1:0]) << (WORK_W - VAR_W);
            sqrt_rem_q <= '0;
            root_q     <= '0;
            iter_q     <= ITER_W'(SQRT_IN_W / 2);
            state_q    <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          work_q     <= work_q << 2;
          sqrt_rem_q <= sqrt_rem_nxt;
          root_q     <= {root_q[SD_W-2:0], sqrt_ge};
          iter_q     <= iter_q - ITER_W'(1);
          if (iter_last) begin
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          // Hold until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_q.pad            <= '0;
            out_q.interval       <= IVL_OUT_W'(last_q);
            out_q.interval_valid <= seen_q;
            out_q.sample_count   <= CNT_OUT_W'(count_q);
            out_q.mean_q8        <= mean_q;
            out_q.variance_int   <= var_q;
            out_q.std_dev_q8     <= root_q;
            out_q.longest        <= IVL_OUT_W'(max_q);
            out_q.shortest       <= IVL_OUT_W'(min_q);
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_LAP)
    else $error("accepted request did not start the sequencer");

  a_count_needs_lap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> count_q == '0)
    else $error("samples counted without a measured lap");

  a_min_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("shortest lap exceeds longest lap");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEAN || state_q == ST_SQDIV || state_q == ST_VARDIV |-> divisor_q != '0)
    else $error("divide by zero in shared divider");

endmodule
